>>> sv/sbe_pkg.sv
// shared types and constants for the stack bytecode executor
// no dependencies; used by sbe_muldiv, stack_bytecode_executor_top and tb_top
package sbe_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int SP_BITS     = $clog2(STACK_DEPTH);
	localparam int DEPTH_BITS  = SP_BITS + 1;
	localparam int VAR_COUNT   = 256;
	localparam int VAR_BITS    = $clog2(VAR_COUNT);
	localparam int PC_BITS     = 16;
	localparam int WORD_BITS   = 32;
	localparam int MD_STEPS    = WORD_BITS;
	localparam int MD_CNT_BITS = $clog2(MD_STEPS) + 1;

	localparam logic [WORD_BITS-1:0] WORD_MOST_NEG = 32'h8000_0000;
	localparam logic [WORD_BITS-1:0] MINUS_ONE     = 32'hFFFF_FFFF;

	// opcodes
	localparam logic [7:0] OP_PUSH_INT  = 8'd0;
	localparam logic [7:0] OP_PUSH_BOOL = 8'd1;
	localparam logic [7:0] OP_PUSH_0    = 8'd2;
	localparam logic [7:0] OP_PUSH_1    = 8'd3;
	localparam logic [7:0] OP_ADD       = 8'd4;
	localparam logic [7:0] OP_SUB       = 8'd5;
	localparam logic [7:0] OP_MUL       = 8'd6;
	localparam logic [7:0] OP_DIV       = 8'd7;
	localparam logic [7:0] OP_MOD       = 8'd8;
	localparam logic [7:0] OP_EQ        = 8'd9;
	localparam logic [7:0] OP_NEQ       = 8'd10;
	localparam logic [7:0] OP_LT        = 8'd11;
	localparam logic [7:0] OP_GT        = 8'd12;
	localparam logic [7:0] OP_LTE       = 8'd13;
	localparam logic [7:0] OP_GTE       = 8'd14;
	localparam logic [7:0] OP_XOR       = 8'd15;
	localparam logic [7:0] OP_AND       = 8'd16;
	localparam logic [7:0] OP_OR        = 8'd17;
	localparam logic [7:0] OP_SHL       = 8'd18;
	localparam logic [7:0] OP_SHR       = 8'd19;
	localparam logic [7:0] OP_BIT_NOT   = 8'd20;
	localparam logic [7:0] OP_NOT       = 8'd21;
	localparam logic [7:0] OP_NORM      = 8'd22;
	localparam logic [7:0] OP_NEG       = 8'd23;
	localparam logic [7:0] OP_POP       = 8'd24;
	localparam logic [7:0] OP_SET_VAR   = 8'd25;
	localparam logic [7:0] OP_GET_VAR   = 8'd26;
	localparam logic [7:0] OP_SET_PUSH  = 8'd27;
	localparam logic [7:0] OP_JMP       = 8'd28;
	localparam logic [7:0] OP_JMP_IF_F  = 8'd29;
	localparam logic [7:0] OP_PRINT     = 8'd30;
	localparam logic [7:0] OP_INPUT     = 8'd31;
	localparam logic [7:0] OP_HALT      = 8'd32;

	// status codes
	localparam logic [3:0] ST_OK     = 4'd0;
	localparam logic [3:0] ST_HALT   = 4'd1;
	localparam logic [3:0] ST_OVER   = 4'd2;
	localparam logic [3:0] ST_UNDER  = 4'd3;
	localparam logic [3:0] ST_ARITH  = 4'd4;
	localparam logic [3:0] ST_DIVZ   = 4'd5;
	localparam logic [3:0] ST_SHIFT  = 4'd6;
	localparam logic [3:0] ST_BADJMP = 4'd7;
	localparam logic [3:0] ST_END    = 4'd8;
	localparam logic [3:0] ST_BADOP  = 4'd9;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD0,
		S_RD1,
		S_RD2,
		S_MD,
		S_WB
	} state_t;

	// request to the multiply / divide unit
	typedef struct packed {
		logic start;
		logic is_mul;
		logic want_rem;
	} md_req_t;

	// response from the multiply / divide unit
	typedef struct packed {
		logic                 done;
		logic                 ovf;
		logic [WORD_BITS-1:0] result;
	} md_rsp_t;

endpackage

>>> sv/sbe_muldiv.sv
// iterative signed multiply / divide / modulo, one bit per cycle on a shared adder
// depends on sbe_pkg
module sbe_muldiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sbe_pkg::md_req_t              req,
	input  logic [sbe_pkg::WORD_BITS-1:0] a,
	input  logic [sbe_pkg::WORD_BITS-1:0] b,
	output sbe_pkg::md_rsp_t              rsp
);
	import sbe_pkg::*;

	logic                   busy_q;
	logic                   fin_q;
	logic                   done_q;
	logic [MD_CNT_BITS-1:0] cnt_q;
	logic                   is_mul_q;
	logic                   want_rem_q;
	logic                   neg_q;
	logic                   asign_q;
	logic [WORD_BITS-1:0]   hi_q;
	logic [WORD_BITS-1:0]   lo_q;
	logic [WORD_BITS-1:0]   d_q;
	logic [WORD_BITS-1:0]   res_q;
	logic                   ovf_q;

	logic [WORD_BITS-1:0]   a_mag;
	logic [WORD_BITS-1:0]   b_mag;
	logic [WORD_BITS+1:0]   add_x;
	logic [WORD_BITS+1:0]   add_y;
	logic                   add_sub;
	logic [WORD_BITS+1:0]   add_sum;
	logic                   div_ok;
	logic [WORD_BITS-1:0]   res_d;
	logic                   ovf_d;

	// operand magnitudes
	assign a_mag = a[WORD_BITS-1] ? (~a + 1'b1) : a;
	assign b_mag = b[WORD_BITS-1] ? (~b + 1'b1) : b;

	// shared adder: add for multiply, subtract for divide
	always_comb begin
		if (is_mul_q) begin
			add_x   = {2'b00, hi_q};
			add_y   = lo_q[0] ? {2'b00, d_q} : '0;
			add_sub = 1'b0;
		end else begin
			add_x   = {1'b0, hi_q, lo_q[WORD_BITS-1]};
			add_y   = {2'b00, d_q};
			add_sub = 1'b1;
		end
		add_sum = add_x + (add_sub ? ~add_y : add_y) + {{(WORD_BITS+1){1'b0}}, add_sub};
		div_ok  = ~add_sum[WORD_BITS+1];
	end

	// sign fix-up and overflow check on the finished magnitude
	always_comb begin
		res_d = '0;
		ovf_d = 1'b0;
		if (is_mul_q) begin
			res_d = neg_q ? (~lo_q + 1'b1) : lo_q;
			ovf_d = (hi_q != '0) ||
				(neg_q ? (lo_q[WORD_BITS-1] && (lo_q[WORD_BITS-2:0] != '0))
				       : lo_q[WORD_BITS-1]);
		end else if (want_rem_q) begin
			res_d = asign_q ? (~hi_q + 1'b1) : hi_q;
		end else begin
			res_d = neg_q ? (~lo_q + 1'b1) : lo_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MD_CNT_BITS'(MD_STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			is_mul_q   <= req.is_mul;
			want_rem_q <= req.want_rem;
			neg_q      <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			asign_q    <= a[WORD_BITS-1];
			hi_q       <= '0;
			lo_q       <= req.is_mul ? b_mag : a_mag;
			d_q        <= req.is_mul ? a_mag : b_mag;
		end else if (busy_q) begin
			if (is_mul_q) begin
				hi_q <= add_sum[WORD_BITS:1];
				lo_q <= {add_sum[0], lo_q[WORD_BITS-1:1]};
			end else begin
				hi_q <= div_ok ? add_sum[WORD_BITS-1:0] : add_x[WORD_BITS-1:0];
				lo_q <= {lo_q[WORD_BITS-2:0], div_ok};
			end
		end
		if (fin_q) begin
			res_q <= res_d;
			ovf_q <= ovf_d;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.ovf    = ovf_q;
	assign rsp.result = res_q;

endmodule

>>> sv/stack_bytecode_executor_top.sv
// top level of the stack bytecode executor: sequencer, operand stack, variable store
// depends on sbe_pkg and sbe_muldiv
//
// Executes one decoded instruction of a 32-bit stack machine per input transaction.
// s_* : instruction in; tdata = func, imm_value, var_index, next_pc, input_value.
// m_* : one result per instruction; tdata = status, pc_out, print_valid, print_value.
// cfg_we / cfg_wdata : writes code_size; the user must write it only while the block is idle (not enforced).
// Each instruction walks a sequencer: two reads of the stack memory's single read
// port (top, then second), with the variable store read alongside the first, then
// write-back; mul, div and mod wait in S_MD for the bit-serial multiply / divide
// unit before write-back. One instruction is in work at a time; s_tready is high
// only while idle.
// When the receiver stalls, the finished result is held in the output register
// and the next instruction may still be taken; its write-back waits until the
// register is free.
// Reset clears stack depth, run state, code_size and the valid bits of the
// variable store (all variables read as zero); no clearing pass is needed.
module stack_bytecode_executor_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// func[7:0], imm_value[39:8], var_index[47:40], next_pc[63:48], input_value[95:64]
	input  logic [95:0]                 s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status[3:0], pc_out[19:4], print_valid[20], print_value[52:21], zero fill
	output logic [55:0]                 m_tdata,
	input  logic                        cfg_we,
	input  logic [sbe_pkg::PC_BITS-1:0] cfg_wdata
);
	import sbe_pkg::*;

	state_t state_q, state_d;

	logic [PC_BITS-1:0]    cs_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [DEPTH_BITS-1:0] start_q;
	logic                  run_active_q;

	logic [7:0]            func_q;
	logic [WORD_BITS-1:0]  imm_q;
	logic [VAR_BITS-1:0]   slot_q;
	logic [PC_BITS-1:0]    npc_q;
	logic [WORD_BITS-1:0]  inval_q;
	logic [WORD_BITS-1:0]  a_q;
	logic [WORD_BITS-1:0]  b_q;
	logic [WORD_BITS-1:0]  var_q;

	logic [WORD_BITS-1:0]  stk_mem [STACK_DEPTH];
	logic [WORD_BITS-1:0]  stk_rdata_q;
	logic [SP_BITS-1:0]    stk_raddr;
	logic                  stk_we;
	logic [SP_BITS-1:0]    stk_waddr;
	logic [WORD_BITS-1:0]  stk_wdata;

	logic [WORD_BITS-1:0]  var_mem [VAR_COUNT];
	logic [WORD_BITS-1:0]  var_rdata_q;
	logic                  var_vld_rd_q;
	logic [VAR_COUNT-1:0]  var_vld_q;
	logic                  var_we;

	logic                  m_tvalid_q;
	logic [55:0]           m_tdata_q;

	logic                  in_fire;
	logic                  out_free;
	logic                  wb_fire;

	md_req_t               md_req;
	md_rsp_t               md_rsp;

	// instruction decode
	logic [1:0]            npop;
	logic                  does_push;
	logic                  is_muldiv;
	logic                  underflow;
	logic [DEPTH_BITS-1:0] dp;

	// write-back values
	logic [WORD_BITS:0]    sum33;
	logic [WORD_BITS:0]    dif33;
	logic [WORD_BITS-1:0]  push_val;
	logic [3:0]            fault_op;
	logic [3:0]            fault_pre;
	logic [3:0]            fault;
	logic                  jump_take;
	logic [PC_BITS+17:0]   tgt;
	logic                  tgt_bad;
	logic [PC_BITS-1:0]    pc_sel;
	logic                  is_halt;
	logic [3:0]            status;
	logic                  pvalid;

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_RD0;
			S_RD0:  state_d = S_RD1;
			S_RD1:  state_d = S_RD2;
			S_RD2:  state_d = (is_muldiv && !underflow) ? S_MD : S_WB;
			S_MD:   if (md_rsp.done) state_d = S_WB;
			S_WB:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready      = 1'b0;
		stk_raddr     = SP_BITS'(depth_q - 1'b1);
		md_req        = '0;
		wb_fire       = 1'b0;
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_RD0:  stk_raddr = SP_BITS'(depth_q - 1'b1);
			S_RD1:  stk_raddr = SP_BITS'(depth_q - 2'd2);
			S_RD2: begin
				md_req.start    = is_muldiv && !underflow;
				md_req.is_mul   = (func_q == OP_MUL);
				md_req.want_rem = (func_q == OP_MOD);
			end
			S_MD:   ;
			S_WB:   wb_fire = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// decode of pops and pushes
	always_comb begin
		npop      = 2'd0;
		does_push = 1'b0;
		if (func_q >= OP_ADD && func_q <= OP_SHR) npop = 2'd2;
		else if ((func_q >= OP_BIT_NOT && func_q <= OP_SET_VAR) || func_q == OP_SET_PUSH ||
			func_q == OP_JMP_IF_F || func_q == OP_PRINT) npop = 2'd1;
		if (func_q <= OP_NEG || func_q == OP_GET_VAR || func_q == OP_SET_PUSH ||
			func_q == OP_INPUT) does_push = 1'b1;
		is_muldiv = (func_q == OP_MUL) || (func_q == OP_DIV) || (func_q == OP_MOD);
		underflow = depth_q < DEPTH_BITS'(npop);
		dp        = depth_q - DEPTH_BITS'(npop);
	end

	// value to push
	always_comb begin
		sum33 = {a_q[WORD_BITS-1], a_q} + {b_q[WORD_BITS-1], b_q};
		dif33 = {a_q[WORD_BITS-1], a_q} - {b_q[WORD_BITS-1], b_q};
		push_val = '0;
		priority case (func_q)
			OP_PUSH_INT:  push_val = imm_q;
			OP_PUSH_BOOL: push_val = {24'd0, imm_q[7:0]};
			OP_PUSH_0:    push_val = '0;
			OP_PUSH_1:    push_val = 32'd1;
			OP_ADD:       push_val = sum33[WORD_BITS-1:0];
			OP_SUB:       push_val = dif33[WORD_BITS-1:0];
			OP_MUL, OP_DIV, OP_MOD: push_val = md_rsp.result;
			OP_EQ:        push_val = {31'd0, a_q == b_q};
			OP_NEQ:       push_val = {31'd0, a_q != b_q};
			OP_LT:        push_val = {31'd0, $signed(a_q) <  $signed(b_q)};
			OP_GT:        push_val = {31'd0, $signed(a_q) >  $signed(b_q)};
			OP_LTE:       push_val = {31'd0, $signed(a_q) <= $signed(b_q)};
			OP_GTE:       push_val = {31'd0, $signed(a_q) >= $signed(b_q)};
			OP_XOR:       push_val = a_q ^ b_q;
			OP_AND:       push_val = a_q & b_q;
			OP_OR:        push_val = a_q | b_q;
			OP_SHL:       push_val = a_q << b_q[4:0];
			OP_SHR:       push_val = WORD_BITS'($signed(a_q) >>> b_q[4:0]);
			OP_BIT_NOT:   push_val = ~b_q;
			OP_NOT:       push_val = {31'd0, b_q == '0};
			OP_NORM:      push_val = {31'd0, b_q != '0};
			OP_NEG:       push_val = ~b_q + 1'b1;
			OP_GET_VAR:   push_val = var_q;
			OP_SET_PUSH:  push_val = b_q;
			OP_INPUT:     push_val = inval_q;
			default:      push_val = '0;
		endcase
	end

	// fault priority: bad opcode, underflow, operation traps, overflow, jump, end
	always_comb begin
		fault_op = ST_OK;
		if (func_q > OP_HALT) fault_op = ST_BADOP;
		else if (underflow) fault_op = ST_UNDER;
		else begin
			priority case (func_q)
				OP_ADD: if (sum33[WORD_BITS] != sum33[WORD_BITS-1]) fault_op = ST_ARITH;
				OP_SUB: if (dif33[WORD_BITS] != dif33[WORD_BITS-1]) fault_op = ST_ARITH;
				OP_MUL: if (md_rsp.ovf) fault_op = ST_ARITH;
				OP_DIV, OP_MOD: begin
					if (b_q == '0) fault_op = ST_DIVZ;
					else if (a_q == WORD_MOST_NEG && b_q == MINUS_ONE) fault_op = ST_ARITH;
				end
				OP_SHL, OP_SHR: if (b_q[WORD_BITS-1:5] != '0) fault_op = ST_SHIFT;
				OP_NEG: if (b_q == WORD_MOST_NEG) fault_op = ST_ARITH;
				default: ;
			endcase
		end
		fault_pre = fault_op;
		if (fault_op == ST_OK && does_push && dp == DEPTH_BITS'(STACK_DEPTH))
			fault_pre = ST_OVER;

		jump_take = (fault_pre == ST_OK) &&
			((func_q == OP_JMP) || (func_q == OP_JMP_IF_F && b_q == '0));
		tgt     = {18'd0, npc_q} + {{(PC_BITS-14){imm_q[WORD_BITS-1]}}, imm_q};
		tgt_bad = tgt[PC_BITS+17] || (tgt > {18'd0, cs_q});

		fault  = fault_pre;
		pc_sel = npc_q;
		if (jump_take) begin
			if (tgt_bad) fault = ST_BADJMP;
			else pc_sel = tgt[PC_BITS-1:0];
		end
		is_halt = (func_q == OP_HALT);
		if (fault == ST_OK && !is_halt && pc_sel >= cs_q) fault = ST_END;
		if (fault != ST_OK) pc_sel = npc_q;

		status = (fault != ST_OK) ? fault : (is_halt ? ST_HALT : ST_OK);
		pvalid = (func_q == OP_PRINT) && (fault == ST_OK);
	end

	// memory writes follow what the instruction did before any jump or end check
	assign stk_we    = wb_fire && does_push && (fault_pre == ST_OK);
	assign stk_waddr = dp[SP_BITS-1:0];
	assign stk_wdata = push_val;
	assign var_we    = wb_fire && (func_q == OP_SET_VAR || func_q == OP_SET_PUSH) && !underflow;

	// operand stack memory
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
		stk_rdata_q <= stk_mem[stk_raddr];
	end

	// variable store memory
	always_ff @(posedge clk) begin
		if (var_we) var_mem[slot_q] <= b_q;
		var_rdata_q <= var_mem[slot_q];
	end

	// variable valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_vld_q    <= '0;
			var_vld_rd_q <= 1'b0;
		end else begin
			if (var_we) var_vld_q[slot_q] <= 1'b1;
			var_vld_rd_q <= var_vld_q[slot_q];
		end
	end

	// instruction and operand registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q  <= s_tdata[7:0];
			imm_q   <= s_tdata[39:8];
			slot_q  <= s_tdata[47:40];
			npc_q   <= s_tdata[63:48];
			inval_q <= s_tdata[95:64];
		end
		if (state_q == S_RD1) begin
			b_q   <= stk_rdata_q;
			var_q <= var_vld_rd_q ? var_rdata_q : '0;
		end
		if (state_q == S_RD2) a_q <= stk_rdata_q;
	end

	// config, depth and run tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q         <= '0;
			depth_q      <= '0;
			start_q      <= '0;
			run_active_q <= 1'b0;
		end else begin
			if (cfg_we) cs_q <= cfg_wdata;
			if (in_fire && !run_active_q) begin
				start_q      <= depth_q;
				run_active_q <= 1'b1;
			end
			if (wb_fire) begin
				if (fault != ST_OK) begin
					depth_q      <= start_q;
					run_active_q <= 1'b0;
				end else begin
					depth_q <= dp + DEPTH_BITS'(does_push);
					if (is_halt) run_active_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (wb_fire) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) m_tdata_q <= {3'd0, (pvalid ? b_q : 32'd0), pvalid, pc_sel, status};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	sbe_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (stk_rdata_q),
		.b      (b_q),
		.rsp    (md_rsp)
	);

	// depth never passes the stack size
	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_BITS'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	// a faulting transaction restores the depth of the run start
	a_fault_restore: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_fire && fault != ST_OK) |=> (depth_q == $past(start_q) && !run_active_q))
		else $error("depth not restored after fault");

	// the multiply / divide unit answers only while the sequencer waits for it
	a_md_done: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> state_q == S_MD)
		else $error("unexpected multiply / divide completion");

	// print data is zero unless print is flagged
	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[20]) |-> m_tdata[52:21] == '0)
		else $error("print value without print flag");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for stack_bytecode_executor_top: directed and random programs
// depends on sbe_pkg and the executor RTL; predicts every result in an internal model
module tb_top;
	import sbe_pkg::*;

	localparam int LIMIT_CYCLES = 1500000;

	typedef struct packed {
		logic [31:0] input_value;
		logic [15:0] next_pc;
		logic [7:0]  var_index;
		logic [31:0] imm_value;
		logic [7:0]  func;
	} instr_t;

	// packed from the top bit down, so status sits in the lowest bits
	typedef struct packed {
		logic [31:0] print_value;
		logic        print_valid;
		logic [15:0] pc_out;
		logic [3:0]  status;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	// model state
	logic [31:0] mdl_stack [STACK_DEPTH];
	logic [31:0] mdl_vars [VAR_COUNT];
	int          mdl_depth;
	int          mdl_run_depth;
	bit          mdl_running;
	logic [15:0] mdl_code_size;

	outcome_t    expected_q[$];
	int          error_count;
	bit          rx_idle_en;
	bit          tx_idle_en;
	int          rx_hold;
	int          rx_gap = 0;
	longint      cycle_count;

	stack_bytecode_executor_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predicted outcome of one instruction, updates model state
	function automatic outcome_t execute_instr(instr_t ins);
		outcome_t    r;
		logic [3:0]  flt;
		logic [31:0] u;
		longint      a, b, t, res;
		bit          halted, jump, chk;
		flt = ST_OK;
		halted = 0;
		jump = 0;
		chk = 0;
		a = 0;
		b = 0;
		res = 0;
		r = '0;
		r.pc_out = ins.next_pc;
		if (!mdl_running) begin
			mdl_run_depth = mdl_depth;
			mdl_running = 1;
		end
		if (ins.func >= OP_ADD && ins.func <= OP_SHR) begin
			if (mdl_depth < 2) flt = ST_UNDER;
			else begin
				b = longint'($signed(mdl_stack[mdl_depth-1]));
				a = longint'($signed(mdl_stack[mdl_depth-2]));
				mdl_depth -= 2;
			end
		end
		if (flt == ST_OK) begin
			// single pops
			if (ins.func inside {OP_BIT_NOT, OP_NOT, OP_NORM, OP_NEG, OP_POP, OP_SET_VAR,
				OP_SET_PUSH, OP_JMP_IF_F, OP_PRINT}) begin
				if (mdl_depth == 0) flt = ST_UNDER;
				else begin
					mdl_depth--;
					u = mdl_stack[mdl_depth];
				end
			end
		end
		if (flt == ST_OK) begin
			case (ins.func)
				OP_PUSH_INT:  res = ins.imm_value;
				OP_PUSH_BOOL: res = ins.imm_value[7:0];
				OP_PUSH_0:    res = 0;
				OP_PUSH_1:    res = 1;
				OP_ADD: begin res = a + b; chk = 1; end
				OP_SUB: begin res = a - b; chk = 1; end
				OP_MUL: begin res = a * b; chk = 1; end
				OP_DIV, OP_MOD: begin
					if (b == 0) flt = ST_DIVZ;
					else if (a == -64'sd2147483648 && b == -1) flt = ST_ARITH;
					else res = (ins.func == OP_DIV) ? a / b : a % b;
				end
				OP_EQ:  res = a == b;
				OP_NEQ: res = a != b;
				OP_LT:  res = a < b;
				OP_GT:  res = a > b;
				OP_LTE: res = a <= b;
				OP_GTE: res = a >= b;
				OP_XOR: res = a[31:0] ^ b[31:0];
				OP_AND: res = a[31:0] & b[31:0];
				OP_OR:  res = a[31:0] | b[31:0];
				OP_SHL, OP_SHR: begin
					if (b < 0 || b >= 32) flt = ST_SHIFT;
					else if (ins.func == OP_SHL) res = a[31:0] << b;
					else res = $unsigned($signed(a[31:0]) >>> b);
				end
				OP_BIT_NOT: res = ~u;
				OP_NOT:     res = u == 0;
				OP_NORM:    res = u != 0;
				OP_NEG: begin
					if (u == WORD_MOST_NEG) flt = ST_ARITH;
					else res = 32'(0 - u);
				end
				OP_SET_VAR, OP_SET_PUSH: begin
					mdl_vars[ins.var_index] = u;
					res = u;
				end
				OP_GET_VAR: res = mdl_vars[ins.var_index];
				OP_JMP:     jump = 1;
				OP_JMP_IF_F: jump = (u == 0);
				OP_PRINT: begin
					r.print_valid = 1;
					r.print_value = u;
				end
				OP_INPUT: res = ins.input_value;
				OP_HALT:  halted = 1;
				OP_POP: ;
				default: flt = ST_BADOP;
			endcase
		end
		if (flt == ST_OK && chk && (res > 64'sd2147483647 || res < -64'sd2147483648))
			flt = ST_ARITH;
		// pushes
		if (flt == ST_OK && (ins.func <= OP_NEG || ins.func == OP_GET_VAR ||
			ins.func == OP_SET_PUSH || ins.func == OP_INPUT)) begin
			if (mdl_depth >= STACK_DEPTH) flt = ST_OVER;
			else begin
				mdl_stack[mdl_depth] = res[31:0];
				mdl_depth++;
			end
		end
		if (flt == ST_OK && jump) begin
			t = longint'(ins.next_pc) + longint'($signed(ins.imm_value));
			if (t < 0 || t > mdl_code_size) flt = ST_BADJMP;
			else r.pc_out = t[15:0];
		end
		if (flt == ST_OK && !halted && r.pc_out >= mdl_code_size) flt = ST_END;
		if (flt != ST_OK) begin
			mdl_depth = mdl_run_depth;
			mdl_running = 0;
			r.pc_out = ins.next_pc;
			r.print_valid = 0;
			r.print_value = 0;
			r.status = flt;
		end else begin
			if (halted) mdl_running = 0;
			r.status = halted ? ST_HALT : ST_OK;
		end
		return r;
	endfunction

	// send one instruction, predicting at acceptance
	// valid stays up after acceptance; a drain takes it down, as may the next call's idle gap
	task automatic send_instr(instr_t ins);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ins;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_q.push_back(execute_instr(ins));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_code_size(logic [15:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_code_size = v;
	endtask

	function automatic instr_t mk(logic [7:0] f, logic [31:0] imm = 0, logic [7:0] vi = 0,
		logic [15:0] npc = 1, logic [31:0] inv = 0);
		instr_t i;
		i.func = f;
		i.imm_value = imm;
		i.var_index = vi;
		i.next_pc = npc;
		i.input_value = inv;
		return i;
	endfunction

	// signed value with a bias toward the extremes
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return WORD_MOST_NEG;
			2: return MINUS_ONE;
			3: return $urandom_range(0, 40);
			4: return 32'($signed(-$urandom_range(0, 40)));
			default: return $urandom;
		endcase
	endfunction

	// random instruction that rarely breaks a run; no reads of unwritten stack entries
	function automatic instr_t rand_instr(bit noisy);
		instr_t i;
		i.func = (noisy && $urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 32));
		if (!noisy && i.func == OP_HALT && $urandom_range(0, 3) != 0) i.func = OP_PUSH_INT;
		i.imm_value = rand_word();
		if (i.func == OP_JMP || i.func == OP_JMP_IF_F)
			i.imm_value = 32'($signed($urandom_range(0, 400)) - 200);
		if ((i.func == OP_SHL || i.func == OP_SHR) && $urandom_range(0, 3) == 0)
			i.imm_value = $urandom_range(0, 31);
		i.var_index = $urandom;
		i.next_pc = (mdl_code_size > 2) ? 16'($urandom_range(0, mdl_code_size - 1)) :
			16'($urandom);
		i.input_value = rand_word();
		return i;
	endfunction

	task automatic test_reset_defaults();
		write_code_size(16'd100);
		send_instr(mk(OP_GET_VAR, 0, 8'd0));
		send_instr(mk(OP_GET_VAR, 0, 8'd255));
		send_instr(mk(OP_ADD));
		send_instr(mk(OP_HALT));
	endtask

	task automatic test_directed_ops();
		send_instr(mk(OP_PUSH_INT, 32'h7FFF_FFFF));
		send_instr(mk(OP_PUSH_1));
		send_instr(mk(OP_ADD));
		send_instr(mk(OP_PUSH_INT, WORD_MOST_NEG));
		send_instr(mk(OP_PUSH_INT, MINUS_ONE));
		send_instr(mk(OP_DIV));
		send_instr(mk(OP_PUSH_1));
		send_instr(mk(OP_PUSH_0));
		send_instr(mk(OP_MOD));
		send_instr(mk(OP_PUSH_INT, WORD_MOST_NEG));
		send_instr(mk(OP_NEG));
		send_instr(mk(OP_PUSH_BOOL, 32'hFFFF_FF80));
		send_instr(mk(OP_PUSH_INT, 32'd32));
		send_instr(mk(OP_SHR));
		send_instr(mk(OP_PUSH_INT, WORD_MOST_NEG, 8'hFF, 16'hFFFF, MINUS_ONE));
		send_instr(mk(OP_PUSH_INT, 32'd31));
		send_instr(mk(OP_SHR));
		send_instr(mk(OP_SET_PUSH, 0, 8'hFF));
		send_instr(mk(OP_JMP_IF_F, 32'd5));
		send_instr(mk(OP_JMP, MINUS_ONE, 0, 16'd0));
		send_instr(mk(OP_JMP, 32'd99, 0, 16'd1));
		send_instr(mk(OP_INPUT, 0, 0, 1, 32'h8000_0001));
		send_instr(mk(OP_PRINT, 0, 0, 16'd99));
		send_instr(mk(8'd33));
		send_instr(mk(8'd255));
	endtask

	// fill the stack to overflow, then pop once and halt
	task automatic test_stack_limits();
		write_code_size(16'hFFFF);
		repeat (STACK_DEPTH + 1) send_instr(mk(OP_PUSH_INT, $urandom));
		send_instr(mk(OP_POP));
		send_instr(mk(OP_HALT));
	endtask

	task automatic test_random_programs(int n, bit idle);
		tx_idle_en = idle;
		rx_idle_en = idle;
		for (int k = 0; k < n; k++) begin
			if (k % 200 == 0) begin
				case ((k / 200) % 4)
					0: write_code_size(16'hFFFF);
					1: write_code_size(16'($urandom_range(1, 1000)));
					2: write_code_size(16'd0);
					default: write_code_size(16'($urandom));
				endcase
			end
			send_instr(rand_instr(k % 7 == 0));
		end
	endtask

	task automatic test_backpressure();
		write_code_size(16'd500);
		tx_idle_en = 0;
		rx_hold = 300;
		repeat (20) send_instr(rand_instr(0));
		drain_results();
		repeat (5) send_instr(rand_instr(0));
	endtask

	// result checker
	always @(posedge clk) begin
		outcome_t got, exp;
		cycle_count <= cycle_count + 1;
		if (m_tvalid && m_tready) begin
			got = m_tdata[52:0];
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction %h", got);
				error_count++;
			end else begin
				exp = expected_q.pop_front();
				if (got.status !== exp.status) begin
					$error("status exp %0d got %0d", exp.status, got.status);
					error_count++;
				end
				if (got.pc_out !== exp.pc_out) begin
					$error("pc_out exp %0d got %0d", exp.pc_out, got.pc_out);
					error_count++;
				end
				if (got.print_valid !== exp.print_valid) begin
					$error("print_valid exp %0d got %0d", exp.print_valid, got.print_valid);
					error_count++;
				end
				if (got.print_value !== exp.print_value) begin
					$error("print_value exp %h got %h", exp.print_value, got.print_value);
					error_count++;
				end
			end
		end
	end

	// receiver stalls in random bursts when idle gaps are on, with one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_gap > 0) begin
			m_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			rx_gap <= $urandom_range(0, 9);
		end else m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		s_tvalid = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		arst_n = 0;
		error_count = 0;
		rx_idle_en = 0;
		tx_idle_en = 0;
		rx_hold = 0;
		cycle_count = 0;
		mdl_depth = 0;
		mdl_run_depth = 0;
		mdl_running = 0;
		mdl_code_size = 0;
		foreach (mdl_vars[i]) mdl_vars[i] = 0;
		foreach (mdl_stack[i]) mdl_stack[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_ops();
		test_stack_limits();
		test_random_programs(1050, 1);
		test_backpressure();
		test_random_programs(200, 0);
		drain_results();
		if (error_count == 0) $display("tb_top: done, clean");
		else $display("tb_top: done, errors");
		$finish;
	end
endmodule
